// ----- hw/rtl/joystick_radial_deadzone_conditioner_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the joystick conditioner
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_RADIAL_DEADZONE_CONDITIONER_DEFINES_SVH
`define JOYSTICK_RADIAL_DEADZONE_CONDITIONER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define JRDC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define JRDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define JRDC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define JRDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/jrdc_pkg.sv -----
// ----------------------------------------------------------------------------
// jrdc_pkg
// Shared widths, constants, types and sequencer states of the conditioner.
// ----------------------------------------------------------------------------
package jrdc_pkg;

   // field widths
   localparam int AXIS_W     = 16;
   localparam int FT_W       = 16;
   localparam int DZ_W       = 15;
   localparam int SENS_W     = 16;
   localparam int OUT_W      = 16;
   localparam int SUM_W      = 48;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 128;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int ACC_BITS_DEFAULT = 48;

   // clamped magnitude, Q2.14, at most 1.0
   localparam int MAG_W = 15;
   localparam logic [MAG_W-1:0] UNIT_Q14 = 15'd16384;
   // squares
   localparam int SQ_W = 32;
   localparam logic [SQ_W-1:0] UNIT_SQ = 32'h1000_0000;

   // serial multiplier: A parallel, B one bit a cycle
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 16;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // root of (s << 16): s has 30 bits, root is the length in Q2.22
   localparam int SQRT_IN_W = 30;
   localparam int ROOT_W    = 23;
   localparam int LEN_FRAC  = 22;
   localparam logic [ROOT_W-1:0] LEN_MIN = 23'h40_0000;

   // divider: (mag << 22 + len/2) / len
   localparam int DIV_NUM_W = MAG_W + LEN_FRAC;
   localparam int DIV_Q_W   = 16;

   // configuration
   localparam logic [DZ_W-1:0]   DZ_RESET   = 15'd1638;
   localparam logic [SENS_W-1:0] SENS_RESET = 16'd256;
   localparam int CSR_IDX_BIT = 2;
   localparam logic CSR_IDX_DEAD_ZONE = 1'b0;
   localparam logic CSR_IDX_SENS      = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_SQR,
      ST_GAIN,
      ST_DZ,
      ST_NORM,
      ST_SQRT,
      ST_DIVX,
      ST_DIVY,
      ST_MULX,
      ST_MULY,
      ST_OUT
   } jrdc_state_type;

endpackage

// ----- hw/rtl/jrdc_mul.sv -----
// ----------------------------------------------------------------------------
// jrdc_mul
// Shift-add multiplier: the B operand is consumed one bit per cycle.
// ----------------------------------------------------------------------------
module jrdc_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [jrdc_pkg::MUL_A_W-1:0]   a,
   input  logic [jrdc_pkg::MUL_B_W-1:0]   b,
   output logic [jrdc_pkg::MUL_P_W-1:0]   product,
   output jrdc_pkg::unit_sts_type         sts
);

   localparam int AW    = jrdc_pkg::MUL_A_W;
   localparam int BW    = jrdc_pkg::MUL_B_W;
   localparam int CNT_W = $clog2(BW);

   logic [AW-1:0]    a_ff, a_in;
   logic [AW-1:0]    hi_ff, hi_in;
   logic [BW-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [AW:0]      sum;

   always_comb begin
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         hi_in   = '0;
         lo_in   = b;
         cnt_in  = CNT_W'(BW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // product shifts right into the multiplier register as its bits retire
         hi_in  = sum[AW:1];
         lo_in  = {sum[0], lo_ff[BW-1:1]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign product = {hi_ff, lo_ff};
   assign sts     = '{busy: busy_ff, done: done_ff};

endmodule

// ----- hw/rtl/jrdc_sqrt.sv -----
// ----------------------------------------------------------------------------
// jrdc_sqrt
// Digit-by-digit integer square root of (s << 16), one root bit per cycle.
// ----------------------------------------------------------------------------
module jrdc_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [jrdc_pkg::SQRT_IN_W-1:0]   radicand,
   output logic [jrdc_pkg::ROOT_W-1:0]      root,
   output jrdc_pkg::unit_sts_type           sts
);

   localparam int IW    = jrdc_pkg::SQRT_IN_W;
   localparam int RW    = jrdc_pkg::ROOT_W;
   localparam int REM_W = RW + 2;
   localparam int CNT_W = $clog2(RW);

   logic [IW-1:0]    rad_ff, rad_in;
   logic [RW-1:0]    root_ff, root_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [REM_W+1:0] rem_sh;
   logic [REM_W+1:0] trial;
   logic [REM_W+1:0] diff;
   logic             fits;

   always_comb begin
      // the low 16 zero bits of the radicand enter as zero pairs after s runs out
      rem_sh  = {rem_ff, rad_ff[IW-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = rem_sh - trial;
      fits    = rem_sh >= trial;
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = CNT_W'(RW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[IW-3:0], 2'b00};
         root_in = {root_ff[RW-2:0], fits};
         rem_in  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign root = root_ff;
   assign sts  = '{busy: busy_ff, done: done_ff};

endmodule

// ----- hw/rtl/jrdc_div.sv -----
// ----------------------------------------------------------------------------
// jrdc_div
// Restoring divider, one quotient bit per cycle; quotient fits 16 bits.
// ----------------------------------------------------------------------------
module jrdc_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [jrdc_pkg::DIV_NUM_W-1:0]   num,
   input  logic [jrdc_pkg::ROOT_W-1:0]      den,
   output logic [jrdc_pkg::DIV_Q_W-1:0]     quo,
   output jrdc_pkg::unit_sts_type           sts
);

   localparam int NW    = jrdc_pkg::DIV_NUM_W;
   localparam int DW    = jrdc_pkg::ROOT_W;
   localparam int QW    = jrdc_pkg::DIV_Q_W;
   localparam int CNT_W = $clog2(QW);

   logic [DW-1:0]    den_ff, den_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [QW-1:0]    low_ff, low_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DW:0]      rem_sh;
   logic [DW:0]      diff;
   logic             fits;

   always_comb begin
      rem_sh  = {rem_ff, low_ff[QW-1]};
      diff    = rem_sh - {1'b0, den_ff};
      fits    = rem_sh >= {1'b0, den_ff};
      den_in  = den_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // upper numerator bits are already below the divisor
         den_in  = den;
         rem_in  = DW'(num[NW-1:QW]);
         low_in  = num[QW-1:0];
         quo_in  = '0;
         cnt_in  = CNT_W'(QW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DW-1:0] : rem_sh[DW-1:0];
         low_in = {low_ff[QW-2:0], 1'b0};
         quo_in = {quo_ff[QW-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;
   assign sts = '{busy: busy_ff, done: done_ff};

endmodule

// ----- hw/rtl/joystick_radial_deadzone_conditioner.sv -----
// ----------------------------------------------------------------------------
// joystick_radial_deadzone_conditioner
// Radial dead zone, unit clamp, normalize and saturating accumulation of
// two-axis stick samples.
// ----------------------------------------------------------------------------
// One sample is processed at a time. An item whose clamped radius is at most
// 1.0 skips the square root and divider; otherwise the vector is scaled to unit
// length. A result may wait on rsp_tready (the next item is accepted while a
// result waits). The time per item is set by one shared shift-add multiplier
// that retires one multiplier bit per cycle and forms six products per item
// (both squares, the squared dead zone, the gain and both increments), by the
// bit-serial square root and by the divider used once per axis. The left and
// right accumulators saturate at ACC_BITS signed bits; sums are reported in
// 48 bits.
// ----------------------------------------------------------------------------
`include "joystick_radial_deadzone_conditioner_defines.svh"

module joystick_radial_deadzone_conditioner #(
   parameter int ACC_BITS = jrdc_pkg::ACC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [jrdc_pkg::REQ_DATA_W-1:0]   req_tdata,  // axis_x, axis_y, frame_time
   input  logic [0:0]                        req_tuser,  // stick_select
   // result items
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [jrdc_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // out_x, out_y, sum_x, sum_y
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [jrdc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [jrdc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [jrdc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int SUM_EXT_W = ((ACC_BITS > jrdc_pkg::SUM_W) ? ACC_BITS : jrdc_pkg::SUM_W) + 1;
   localparam logic signed [SUM_EXT_W-1:0] ACC_HI =
      {{(SUM_EXT_W - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
   localparam logic signed [SUM_EXT_W-1:0] ACC_LO =
      {{(SUM_EXT_W - ACC_BITS + 1){1'b1}}, {(ACC_BITS - 1){1'b0}}};

   localparam int AXW  = jrdc_pkg::AXIS_W;
   localparam int MGW  = jrdc_pkg::MAG_W;
   localparam int SQW  = jrdc_pkg::SQ_W;
   localparam int PW   = jrdc_pkg::MUL_P_W;
   localparam int OW   = jrdc_pkg::OUT_W;
   localparam int SW   = jrdc_pkg::SUM_W;

   // sequencer
   jrdc_pkg::jrdc_state_type state_ff, state_in;
   logic first_ff, first_in;
   logic out_load;

   // configuration registers
   logic [jrdc_pkg::DZ_W-1:0]   dz_ff;
   logic [jrdc_pkg::SENS_W-1:0] sens_ff;
   logic                        csr_idx;
   logic                        csr_write;

   // item registers
   logic                        sel_ff;
   logic                        xs_ff, ys_ff;
   logic [AXW-1:0]              xm_ff, ym_ff;
   logic [jrdc_pkg::FT_W-1:0]   ft_ff;
   logic [SQW-1:0]              x2_ff, y2_ff;
   logic [jrdc_pkg::SQRT_IN_W-1:0] r2_ff;
   logic [SQW-1:0]              gain_ff;
   logic [jrdc_pkg::SQRT_IN_W-1:0] s_ff;
   logic [jrdc_pkg::ROOT_W-1:0] len_ff;
   logic [MGW-1:0]              ox_ff, oy_ff;
   logic [PW-1:0]               incx_ff, incy_ff;

   // accumulators: left/right per axis
   logic [ACC_BITS-1:0]         acc_x_ff [2];
   logic [ACC_BITS-1:0]         acc_y_ff [2];
   logic [ACC_BITS-1:0]         acc_x_new, acc_y_new;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [OW-1:0]        out_x_ff, out_y_ff;
   logic [SW-1:0]               sum_x_ff, sum_y_ff;

   // arithmetic units
   logic                        mul_start, sqrt_start, div_start;
   logic [jrdc_pkg::MUL_A_W-1:0] mul_a;
   logic [jrdc_pkg::MUL_B_W-1:0] mul_b;
   logic [PW-1:0]               mul_p;
   logic [jrdc_pkg::ROOT_W-1:0] sqrt_root;
   logic [jrdc_pkg::DIV_NUM_W-1:0] div_num;
   logic [MGW-1:0]              div_mag;
   logic [jrdc_pkg::DIV_Q_W-1:0] div_q;
   jrdc_pkg::unit_sts_type      mul_sts, sqrt_sts, div_sts;

   // combinational helpers
   logic [AXW-1:0]              in_xm, in_ym;
   logic [SQW:0]                s_raw;
   logic                        in_dead;
   logic [SQW-1:0]              s_clamp;
   logic                        norm_req;
   logic [MGW-1:0]              q_lim;

   function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] acc,
                                                   input logic neg,
                                                   input logic [PW-1:0] mag);
      logic signed [SUM_EXT_W-1:0] acc_ext;
      logic signed [SUM_EXT_W-1:0] inc_ext;
      logic signed [SUM_EXT_W-1:0] total;
      logic [ACC_BITS-1:0]         res;
      acc_ext = {{(SUM_EXT_W - ACC_BITS){acc[ACC_BITS-1]}}, acc};
      inc_ext = SUM_EXT_W'(mag);
      if (neg) begin
         inc_ext = -inc_ext;
      end
      total = acc_ext + inc_ext;
      priority if (total > ACC_HI) begin
         res = ACC_HI[ACC_BITS-1:0];
      end else if (total < ACC_LO) begin
         res = ACC_LO[ACC_BITS-1:0];
      end else begin
         res = total[ACC_BITS-1:0];
      end
      return res;
   endfunction

   function automatic logic [SW-1:0] sum_field(input logic [ACC_BITS-1:0] acc);
      logic [SUM_EXT_W-1:0] ext;
      ext = {{(SUM_EXT_W - ACC_BITS){acc[ACC_BITS-1]}}, acc};
      return ext[SW-1:0];
   endfunction

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[jrdc_pkg::CSR_IDX_BIT];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff   <= jrdc_pkg::DZ_RESET;
         sens_ff <= jrdc_pkg::SENS_RESET;
      end else if (csr_write) begin
         unique case (csr_idx)
            jrdc_pkg::CSR_IDX_DEAD_ZONE: dz_ff   <= csr_pwdata[jrdc_pkg::DZ_W-1:0];
            jrdc_pkg::CSR_IDX_SENS:      sens_ff <= csr_pwdata[jrdc_pkg::SENS_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         jrdc_pkg::CSR_IDX_DEAD_ZONE: csr_prdata = jrdc_pkg::CSR_DATA_W'(dz_ff);
         jrdc_pkg::CSR_IDX_SENS:      csr_prdata = jrdc_pkg::CSR_DATA_W'(sens_ff);
      endcase
   end

   // ---------------------------------------------------------------- datapath
   assign in_xm = req_tdata[15] ? (~req_tdata[15:0] + AXW'(1)) : req_tdata[15:0];
   assign in_ym = req_tdata[31] ? (~req_tdata[31:16] + AXW'(1)) : req_tdata[31:16];

   // dead-zone test on the raw squared radius
   assign s_raw   = {1'b0, x2_ff} + {1'b0, y2_ff};
   assign in_dead = s_raw < (SQW + 1)'(r2_ff);

   // after the dead-zone step x2/y2 hold the clamped squares
   assign s_clamp  = x2_ff + y2_ff;
   assign norm_req = s_clamp > jrdc_pkg::UNIT_SQ;

   assign div_mag = (state_ff == jrdc_pkg::ST_DIVY) ? oy_ff : ox_ff;
   // round half away from zero: add half the length before dividing
   assign div_num = {div_mag, {jrdc_pkg::LEN_FRAC{1'b0}}} +
                    jrdc_pkg::DIV_NUM_W'(len_ff >> 1);
   assign q_lim   = (div_q > jrdc_pkg::DIV_Q_W'(jrdc_pkg::UNIT_Q14)) ?
                    jrdc_pkg::UNIT_Q14 : div_q[MGW-1:0];

   always_comb begin
      unique case (state_ff)
         jrdc_pkg::ST_SQX: begin
            mul_a = jrdc_pkg::MUL_A_W'(xm_ff);
            mul_b = xm_ff;
         end
         jrdc_pkg::ST_SQY: begin
            mul_a = jrdc_pkg::MUL_A_W'(ym_ff);
            mul_b = ym_ff;
         end
         jrdc_pkg::ST_SQR: begin
            mul_a = jrdc_pkg::MUL_A_W'(dz_ff);
            mul_b = jrdc_pkg::MUL_B_W'(dz_ff);
         end
         jrdc_pkg::ST_GAIN: begin
            mul_a = jrdc_pkg::MUL_A_W'(sens_ff);
            mul_b = ft_ff;
         end
         jrdc_pkg::ST_MULY: begin
            mul_a = gain_ff;
            mul_b = jrdc_pkg::MUL_B_W'(oy_ff);
         end
         default: begin
            mul_a = gain_ff;
            mul_b = jrdc_pkg::MUL_B_W'(ox_ff);
         end
      endcase
   end

   assign mul_start  = first_ff && ((state_ff == jrdc_pkg::ST_SQX) ||
                                    (state_ff == jrdc_pkg::ST_SQY) ||
                                    (state_ff == jrdc_pkg::ST_SQR) ||
                                    (state_ff == jrdc_pkg::ST_GAIN) ||
                                    (state_ff == jrdc_pkg::ST_MULX) ||
                                    (state_ff == jrdc_pkg::ST_MULY));
   assign sqrt_start = first_ff && (state_ff == jrdc_pkg::ST_SQRT);
   assign div_start  = first_ff && ((state_ff == jrdc_pkg::ST_DIVX) ||
                                    (state_ff == jrdc_pkg::ST_DIVY));

   jrdc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_p),
      .sts     (mul_sts)
   );

   jrdc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (s_ff),
      .root     (sqrt_root),
      .sts      (sqrt_sts)
   );

   jrdc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (len_ff),
      .quo   (div_q),
      .sts   (div_sts)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         jrdc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = jrdc_pkg::ST_SQX;
         end
         jrdc_pkg::ST_SQX:  if (mul_sts.done) state_in = jrdc_pkg::ST_SQY;
         jrdc_pkg::ST_SQY:  if (mul_sts.done) state_in = jrdc_pkg::ST_SQR;
         jrdc_pkg::ST_SQR:  if (mul_sts.done) state_in = jrdc_pkg::ST_GAIN;
         jrdc_pkg::ST_GAIN: if (mul_sts.done) state_in = jrdc_pkg::ST_DZ;
         jrdc_pkg::ST_DZ:   state_in = jrdc_pkg::ST_NORM;
         jrdc_pkg::ST_NORM: state_in = norm_req ? jrdc_pkg::ST_SQRT : jrdc_pkg::ST_MULX;
         jrdc_pkg::ST_SQRT: if (sqrt_sts.done) state_in = jrdc_pkg::ST_DIVX;
         jrdc_pkg::ST_DIVX: if (div_sts.done) state_in = jrdc_pkg::ST_DIVY;
         jrdc_pkg::ST_DIVY: if (div_sts.done) state_in = jrdc_pkg::ST_MULX;
         jrdc_pkg::ST_MULX: if (mul_sts.done) state_in = jrdc_pkg::ST_MULY;
         jrdc_pkg::ST_MULY: if (mul_sts.done) state_in = jrdc_pkg::ST_OUT;
         jrdc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = jrdc_pkg::ST_IDLE;
            end
         end
         default: state_in = jrdc_pkg::ST_IDLE;
      endcase
   end

   // a unit is launched in the first cycle of its state
   assign first_in     = state_in != state_ff;
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jrdc_pkg::ST_IDLE;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sel_ff <= req_tuser[0];
         xs_ff  <= req_tdata[15];
         ys_ff  <= req_tdata[31];
         xm_ff  <= in_xm;
         ym_ff  <= in_ym;
         ft_ff  <= req_tdata[47:32];
      end
      if (mul_sts.done && (state_ff == jrdc_pkg::ST_SQX)) x2_ff   <= mul_p[SQW-1:0];
      if (mul_sts.done && (state_ff == jrdc_pkg::ST_SQY)) y2_ff   <= mul_p[SQW-1:0];
      if (mul_sts.done && (state_ff == jrdc_pkg::ST_SQR)) begin
         r2_ff <= mul_p[jrdc_pkg::SQRT_IN_W-1:0];
      end
      if (mul_sts.done && (state_ff == jrdc_pkg::ST_GAIN)) gain_ff <= mul_p[SQW-1:0];
      if (state_ff == jrdc_pkg::ST_DZ) begin
         // zero inside the dead zone, else clamp; the square follows the clamp
         if (in_dead) begin
            ox_ff <= '0;
            oy_ff <= '0;
            x2_ff <= '0;
            y2_ff <= '0;
         end else begin
            if (xm_ff > AXW'(jrdc_pkg::UNIT_Q14)) begin
               ox_ff <= jrdc_pkg::UNIT_Q14;
               x2_ff <= jrdc_pkg::UNIT_SQ;
            end else begin
               ox_ff <= xm_ff[MGW-1:0];
            end
            if (ym_ff > AXW'(jrdc_pkg::UNIT_Q14)) begin
               oy_ff <= jrdc_pkg::UNIT_Q14;
               y2_ff <= jrdc_pkg::UNIT_SQ;
            end else begin
               oy_ff <= ym_ff[MGW-1:0];
            end
         end
      end
      if (state_ff == jrdc_pkg::ST_NORM) s_ff <= s_clamp[jrdc_pkg::SQRT_IN_W-1:0];
      if (sqrt_sts.done) len_ff <= sqrt_root;
      if (div_sts.done && (state_ff == jrdc_pkg::ST_DIVX)) ox_ff <= q_lim;
      if (div_sts.done && (state_ff == jrdc_pkg::ST_DIVY)) oy_ff <= q_lim;
      if (mul_sts.done && (state_ff == jrdc_pkg::ST_MULX)) incx_ff <= mul_p;
      if (mul_sts.done && (state_ff == jrdc_pkg::ST_MULY)) incy_ff <= mul_p;
      if (out_load) begin
         out_x_ff <= xs_ff ? -{1'b0, ox_ff} : {1'b0, ox_ff};
         out_y_ff <= ys_ff ? -{1'b0, oy_ff} : {1'b0, oy_ff};
         sum_x_ff <= sum_field(acc_x_new);
         sum_y_ff <= sum_field(acc_y_new);
      end
   end

   assign acc_x_new = sat_add(acc_x_ff[sel_ff], xs_ff, incx_ff);
   assign acc_y_new = sat_add(acc_y_ff[sel_ff], ys_ff, incy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_x_ff[0] <= '0;
         acc_x_ff[1] <= '0;
         acc_y_ff[0] <= '0;
         acc_y_ff[1] <= '0;
      end else if (out_load) begin
         acc_x_ff[sel_ff] <= acc_x_new;
         acc_y_ff[sel_ff] <= acc_y_new;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {sum_y_ff, sum_x_ff, out_y_ff, out_x_ff};

   // ---------------------------------------------------------------- checks
   `JRDC_ASSERT_IMPLY(a_out_unit, clock, reset, rsp_valid_ff, (out_x_ff <= 16'sd16384) && (out_x_ff >= -16'sd16384) && (out_y_ff <= 16'sd16384) && (out_y_ff >= -16'sd16384), "conditioned output beyond unit range")
   `JRDC_ASSERT_IMPLY(a_one_unit, clock, reset, 1'b1, $onehot0({mul_sts.busy, sqrt_sts.busy, div_sts.busy}), "two arithmetic units busy at once")
   `JRDC_ASSERT_IMPLY(a_norm_len, clock, reset, state_ff == jrdc_pkg::ST_DIVX, len_ff >= jrdc_pkg::LEN_MIN, "normalize length below 1.0")
   `JRDC_ASSERT_NEXT(a_accept_launch, clock, reset, req_tvalid && req_tready, (state_ff == jrdc_pkg::ST_SQX) && first_ff, "accepted item did not launch")

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Streams two-axis stick samples into the radial dead-zone conditioner under
// several dead-zone and gain settings. Every result is checked field by field
// against a behavioral predictor of the dead zone, clamp, normalize and
// saturating per-stick sums. Sender bursts, receiver stalls and one long
// receiver hold-off are applied on top.
// ----------------------------------------------------------------------------
module testbench;

   localparam int ACC_BITS        = jrdc_pkg::ACC_BITS_DEFAULT;
   localparam int CLK_HALF        = 6;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 244;
   localparam int NUM_DIRECTED    = 24;
   localparam int PRESSURE_AT     = 300;
   localparam int PRESSURE_CYCLES = 700;
   localparam int DRAIN_CYCLES    = 250;
   localparam int TIMEOUT_CYCLES  = 2_000_000;
   localparam int UNIT            = int'(jrdc_pkg::UNIT_Q14);
   localparam int DIAG_UNIT       = 11585;   // 1.0 / sqrt(2) in Q2.14

   localparam logic [jrdc_pkg::CSR_ADDR_W-1:0] ADDR_DEAD_ZONE =
      {jrdc_pkg::CSR_IDX_DEAD_ZONE, 2'b00};
   localparam logic [jrdc_pkg::CSR_ADDR_W-1:0] ADDR_SENS =
      {jrdc_pkg::CSR_IDX_SENS, 2'b00};

   localparam longint SUM_HI = (longint'(1) <<< (ACC_BITS - 1)) - 1;
   localparam longint SUM_LO = -SUM_HI - 1;

   localparam int AXIS_EXTREMES [0:6] = '{-32768, -16384, -1, 0, 1, 16384, 32767};

   typedef struct packed {
      logic [jrdc_pkg::FT_W-1:0]          frame_time;
      logic signed [jrdc_pkg::AXIS_W-1:0] axis_y;
      logic signed [jrdc_pkg::AXIS_W-1:0] axis_x;
   } sample_data_type;

   typedef struct packed {
      logic signed [jrdc_pkg::SUM_W-1:0] sum_y;
      logic signed [jrdc_pkg::SUM_W-1:0] sum_x;
      logic signed [jrdc_pkg::OUT_W-1:0] out_y;
      logic signed [jrdc_pkg::OUT_W-1:0] out_x;
   } cond_result_type;

   typedef struct packed {
      logic                               stick;
      logic signed [jrdc_pkg::AXIS_W-1:0] ax;
      logic signed [jrdc_pkg::AXIS_W-1:0] ay;
      logic [jrdc_pkg::FT_W-1:0]          ft;
      logic                               typed;
      logic signed [jrdc_pkg::OUT_W-1:0]  ex;
      logic signed [jrdc_pkg::OUT_W-1:0]  ey;
   } directed_row_type;

   typedef enum int {RX_STREAM, RX_HALF, RX_SPARSE} rx_mode_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [jrdc_pkg::REQ_DATA_W-1:0]   req_tdata = '0;  // axis_x, axis_y, frame_time
   logic [0:0]                        req_tuser = '0;  // stick_select
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [jrdc_pkg::RSP_DATA_W-1:0]   rsp_tdata;       // out_x, out_y, sum_x, sum_y
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [jrdc_pkg::CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [jrdc_pkg::CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [jrdc_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                              csr_pready;

   // predictor state
   logic [jrdc_pkg::DZ_W-1:0]   dz_cfg = jrdc_pkg::DZ_RESET;
   logic [jrdc_pkg::SENS_W-1:0] sens_cfg = jrdc_pkg::SENS_RESET;
   longint                      stick_sums [0:3] = '{0, 0, 0, 0};
   cond_result_type             pending_results [$];

   int          samples_sent = 0;
   int          results_seen = 0;
   int          mismatch_count = 0;
   int          dz_zeroed = 0;
   int          normalized_count = 0;
   int          sat_hits = 0;
   int          burst_left = 0;
   int          hold_left = 0;
   int          mode_left = 0;
   bit          pressure_done = 1'b0;
   rx_mode_type stall_mode = RX_STREAM;

   // stick, x, y, frame time, typed, expected x, expected y
   directed_row_type directed_rows [0:NUM_DIRECTED-1] = '{
      '{1'b0, 16'sd0, 16'sd0, 16'd65535, 1'b1, 16'sd0, 16'sd0},
      '{1'b0, 16'sd1638, 16'sd0, 16'd65535, 1'b1, 16'sd1638, 16'sd0},
      '{1'b0, 16'sd1637, 16'sd0, 16'd65535, 1'b1, 16'sd0, 16'sd0},
      '{1'b1, 16'sd1, 16'sd1638, 16'd1, 1'b1, 16'sd1, 16'sd1638},
      '{1'b1, -16'sd1158, -16'sd1158, 16'd65535, 1'b1, 16'sd0, 16'sd0},
      '{1'b0, 16'sd16384, 16'sd0, 16'd65535, 1'b1, 16'sd16384, 16'sd0},
      '{1'b0, -16'sd16384, 16'sd0, 16'd65535, 1'b1, -16'sd16384, 16'sd0},
      '{1'b1, 16'sd32767, 16'sd0, 16'd43690, 1'b1, 16'sd16384, 16'sd0},
      '{1'b1, -16'sd32768, 16'sd0, 16'd21845, 1'b1, -16'sd16384, 16'sd0},
      '{1'b0, 16'sd0, 16'sd32767, 16'd65535, 1'b1, 16'sd0, 16'sd16384},
      '{1'b0, 16'sd0, -16'sd32768, 16'd65535, 1'b1, 16'sd0, -16'sd16384},
      '{1'b1, 16'sd11585, 16'sd11585, 16'd65535, 1'b1, 16'sd11585, 16'sd11585},
      '{1'b1, 16'sd11586, 16'sd11586, 16'd65535, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, 16'sd16384, 16'sd1, 16'd65535, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, 16'sd16384, 16'sd16384, 16'd65535, 1'b0, 16'sd0, 16'sd0},
      '{1'b1, 16'sd32767, 16'sd32767, 16'd65535, 1'b0, 16'sd0, 16'sd0},
      '{1'b1, -16'sd32768, -16'sd32768, 16'd65535, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, -16'sd32768, 16'sd32767, 16'd65535, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, 16'sd21845, -16'sd21846, 16'd43690, 1'b0, 16'sd0, 16'sd0},
      '{1'b1, -16'sd21846, 16'sd21845, 16'd21845, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, -16'sd2000, 16'sd1500, 16'd0, 1'b1, -16'sd2000, 16'sd1500},
      '{1'b1, 16'sd12345, -16'sd5432, 16'd65535, 1'b1, 16'sd12345, -16'sd5432},
      '{1'b0, -16'sd1, -16'sd1, 16'd65535, 1'b1, 16'sd0, 16'sd0},
      '{1'b1, 16'sd300, -16'sd16383, 16'd65535, 1'b0, 16'sd0, 16'sd0}
   };

   joystick_radial_deadzone_conditioner #(
      .ACC_BITS(ACC_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #(CLK_HALF) clock = ~clock;

   function automatic longint clip_unit(input longint a);
      if (a > UNIT) return UNIT;
      if (a < -UNIT) return -UNIT;
      return a;
   endfunction

   // round half away from zero, capped at 1.0
   function automatic longint unit_scale(input longint a, input longint len);
      longint mag;
      longint q;
      mag = (a < 0) ? -a : a;
      q = ((mag <<< jrdc_pkg::LEN_FRAC) + (len >>> 1)) / len;
      if (q > UNIT) q = UNIT;
      return (a < 0) ? -q : q;
   endfunction

   function automatic longint sat_acc(input longint v);
      if (v > SUM_HI) begin
         sat_hits++;
         return SUM_HI;
      end
      if (v < SUM_LO) begin
         sat_hits++;
         return SUM_LO;
      end
      return v;
   endfunction

   function automatic cond_result_type condition_sample(input logic stick,
                                                        input sample_data_type smp);
      longint          x;
      longint          y;
      longint          sq;
      longint          len;
      longint          cand;
      longint          gain;
      int              base;
      cond_result_type r;
      base = stick ? 2 : 0;
      x = longint'($signed(smp.axis_x));
      y = longint'($signed(smp.axis_y));
      // dead zone works on the raw, unclamped sample
      sq = x * x + y * y;
      if (sq < longint'(dz_cfg) * longint'(dz_cfg)) begin
         x = 0;
         y = 0;
         dz_zeroed++;
      end
      x = clip_unit(x);
      y = clip_unit(y);
      sq = x * x + y * y;
      if (sq > longint'(jrdc_pkg::UNIT_SQ)) begin
         // length in Q2.22: floor of the root of sq * 2^16
         len = 0;
         for (int b = jrdc_pkg::ROOT_W; b >= 0; b--) begin
            cand = len | (longint'(1) <<< b);
            if (cand * cand <= (sq <<< 16)) len = cand;
         end
         x = unit_scale(x, len);
         y = unit_scale(y, len);
         normalized_count++;
      end
      gain = longint'(sens_cfg) * longint'(smp.frame_time);
      stick_sums[base] = sat_acc(stick_sums[base] + x * gain);
      stick_sums[base + 1] = sat_acc(stick_sums[base + 1] + y * gain);
      r.out_x = x[jrdc_pkg::OUT_W-1:0];
      r.out_y = y[jrdc_pkg::OUT_W-1:0];
      r.sum_x = stick_sums[base][jrdc_pkg::SUM_W-1:0];
      r.sum_y = stick_sums[base + 1][jrdc_pkg::SUM_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name,
                              input logic signed [jrdc_pkg::SUM_W-1:0] want,
                              input logic signed [jrdc_pkg::SUM_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // write, then read back
   task automatic write_reg(input logic [jrdc_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [jrdc_pkg::CSR_DATA_W-1:0] value);
      logic [jrdc_pkg::CSR_DATA_W-1:0] readback;
      string                           reg_name;
      if (addr == ADDR_DEAD_ZONE) begin
         dz_cfg = value[jrdc_pkg::DZ_W-1:0];
         readback = jrdc_pkg::CSR_DATA_W'(dz_cfg);
         reg_name = "dead_zone_radius";
      end else begin
         sens_cfg = value[jrdc_pkg::SENS_W-1:0];
         readback = jrdc_pkg::CSR_DATA_W'(sens_cfg);
         reg_name = "sensitivity";
      end
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock) csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock) csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== readback) begin
         $error("%s mismatch: expected %0d, got %0d", reg_name, readback, csr_prdata);
         mismatch_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // offer one item; valid stays up across a burst
   task automatic offer_sample(input logic stick, input sample_data_type smp,
                               input logic typed,
                               input logic signed [jrdc_pkg::OUT_W-1:0] typed_x,
                               input logic signed [jrdc_pkg::OUT_W-1:0] typed_y);
      cond_result_type want;
      int              idle_gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= smp;
      req_tuser <= stick;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = condition_sample(stick, smp);
      if (typed) begin
         want.out_x = typed_x;
         want.out_y = typed_y;
      end
      pending_results.push_back(want);
      samples_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         idle_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
         burst_left = $urandom_range(1, 30);
         if (idle_gap > 0) begin
            @(negedge clock) req_tvalid <= 1'b0;
            repeat (idle_gap - 1) @(negedge clock);
         end
      end
   endtask

   // receiver stall pattern, plus one long hold-off to back up the input
   always @(negedge clock) begin
      if (!reset && !pressure_done && results_seen >= PRESSURE_AT) begin
         hold_left = PRESSURE_CYCLES;
         pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(16, 160);
         end
         mode_left--;
         case (stall_mode)
            RX_STREAM: rsp_tready <= 1'b1;
            RX_HALF:   rsp_tready <= ($urandom_range(0, 1) == 1);
            default:   rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin : result_check
      cond_result_type got;
      cond_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected item: out_x %0d, out_y %0d", got.out_x, got.out_y);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("out_x", jrdc_pkg::SUM_W'(want.out_x),
                        jrdc_pkg::SUM_W'(got.out_x));
            check_field("out_y", jrdc_pkg::SUM_W'(want.out_y),
                        jrdc_pkg::SUM_W'(got.out_y));
            check_field("sum_x", want.sum_x, got.sum_x);
            check_field("sum_y", want.sum_y, got.sum_y);
         end
      end
   end

   initial begin : stimulus
      sample_data_type smp;
      logic            stick;
      int              kind;
      int              mag;
      int              other;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         smp.axis_x = directed_rows[i].ax;
         smp.axis_y = directed_rows[i].ay;
         smp.frame_time = directed_rows[i].ft;
         offer_sample(directed_rows[i].stick, smp, directed_rows[i].typed,
                      directed_rows[i].ex, directed_rows[i].ey);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            // registers change only with nothing in flight
            @(negedge clock) req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
            case (phase)
               1: begin
                  write_reg(ADDR_DEAD_ZONE, 32'd0);
                  write_reg(ADDR_SENS, 32'd65535);
               end
               2: begin
                  write_reg(ADDR_DEAD_ZONE, 32'd23170);
                  write_reg(ADDR_SENS, 32'd1);
               end
               3: begin
                  // upper bits dropped: dead zone past its range, zero gain
                  write_reg(ADDR_DEAD_ZONE, 32'hFFFF_FFFF);
                  write_reg(ADDR_SENS, 32'hFFFF_0000);
               end
               7: begin
                  write_reg(ADDR_DEAD_ZONE, jrdc_pkg::CSR_DATA_W'(jrdc_pkg::DZ_RESET));
                  write_reg(ADDR_SENS, jrdc_pkg::CSR_DATA_W'(jrdc_pkg::SENS_RESET));
               end
               default: begin
                  write_reg(ADDR_DEAD_ZONE, $urandom_range(0, 23170));
                  write_reg(ADDR_SENS, $urandom_range(0, 65535));
               end
            endcase
         end

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            stick = 1'($urandom_range(0, 1));
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
               smp.frame_time = $urandom_range(0, 1) ? '1 : '0;
            else
               smp.frame_time = jrdc_pkg::FT_W'($urandom);
            if (kind < 40) begin
               smp.axis_x = jrdc_pkg::AXIS_W'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
               smp.axis_y = jrdc_pkg::AXIS_W'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
            end else if (kind < 60) begin
               smp.axis_x = jrdc_pkg::AXIS_W'($urandom);
               smp.axis_y = jrdc_pkg::AXIS_W'($urandom);
            end else if (kind < 90) begin
               if (kind < 75) begin
                  // around the dead-zone edge
                  mag = int'(dz_cfg) + int'($urandom_range(0, 4)) - 2;
                  if (mag < 0) mag = 0;
                  if (mag > 32767) mag = 32767;
                  other = int'($urandom_range(0, 6)) - 3;
               end else if (kind < 83) begin
                  // around the unit circle on an axis
                  mag = UNIT + int'($urandom_range(0, 4)) - 2;
                  other = int'($urandom_range(0, 8)) - 4;
               end else begin
                  mag = DIAG_UNIT + int'($urandom_range(0, 2)) - 1;
                  other = DIAG_UNIT + int'($urandom_range(0, 2)) - 1;
               end
               if ($urandom_range(0, 1)) mag = -mag;
               if ($urandom_range(0, 1)) other = -other;
               if ($urandom_range(0, 1)) begin
                  smp.axis_x = jrdc_pkg::AXIS_W'(mag);
                  smp.axis_y = jrdc_pkg::AXIS_W'(other);
               end else begin
                  smp.axis_x = jrdc_pkg::AXIS_W'(other);
                  smp.axis_y = jrdc_pkg::AXIS_W'(mag);
               end
            end else begin
               smp.axis_x = jrdc_pkg::AXIS_W'(AXIS_EXTREMES[$urandom_range(0, 6)]);
               smp.axis_y = jrdc_pkg::AXIS_W'(AXIS_EXTREMES[$urandom_range(0, 6)]);
            end
            offer_sample(stick, smp, 1'b0, '0, '0);
         end
      end

      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d stick samples over %0d register settings, %0d results checked.",
               samples_sent, NUM_PHASES, results_seen);
      $display("Dead zone zeroed %0d, unit-length scaling %0d, sum saturations %0d.",
               dz_zeroed, normalized_count, sat_hits);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin : watchdog
      #(2 * CLK_HALF * TIMEOUT_CYCLES);
      $display("FAIL");
      $finish;
   end

endmodule
